@@ design/humidity_temp_frame_decoder_macros.svh @@
// Assertion macros shared by the frame decoder modules.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HFD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("frame decoder check failed");
`define HFD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame decoder check failed");
`define HFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame decoder check failed");
`else
`define HFD_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define HFD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define HFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/hfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte function of the frame decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hfd_pkg;

  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] BUSY_MASK  = 8'h80;
  localparam logic [7:0] LOW_NIBBLE = 8'h0F;
  localparam logic [2:0] FRAME_LAST = 3'd6;
  localparam int unsigned PAYLOAD_LEN = 5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // Fixed-point scales: value = floor(raw * scale / 2^20), less TEMP_OFFSET for temperature.
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;
  localparam int unsigned RAW_W  = 20;
  localparam int unsigned HPROD_W = RAW_W + 14;
  localparam int unsigned TPROD_W = RAW_W + 15;

  typedef struct packed {
    logic [1:0]       result_status;
    logic [7:0]       status_byte;
    logic [RAW_W-1:0] humidity_raw;
    logic [RAW_W-1:0] temperature_raw;
    logic [7:0]       computed_check;
  } frame_rec_t;

  // CRC-8, MSB first, one byte folded in.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/hfd_in_if.sv @@
// Byte channel into the frame decoder: valid/ready plus one frame byte.
// Depends on nothing but the clock domain of its user.
`timescale 1ns / 1ps
`default_nettype none
interface hfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface
`default_nettype wire

@@ design/hfd_out_if.sv @@
// Result channel out of the frame decoder: valid/ready plus one decoded reading.
// Depends on hfd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface hfd_out_if import hfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              result_status;
  logic [7:0]              status_byte;
  logic [RAW_W-1:0]        humidity_raw;
  logic [RAW_W-1:0]        temperature_raw;
  logic [13:0]             humidity_centi;
  logic signed [14:0]      temperature_centi;
  logic [7:0]              computed_check;

  modport source (output valid, output result_status, output status_byte,
                  output humidity_raw, output temperature_raw, output humidity_centi,
                  output temperature_centi, output computed_check, input ready);
  modport sink   (input valid, input result_status, input status_byte,
                  input humidity_raw, input temperature_raw, input humidity_centi,
                  input temperature_centi, input computed_check, output ready);
endinterface
`default_nettype wire

@@ design/humidity_temp_frame_decoder.sv @@
// Humidity/temperature frame decoder: one byte accepted per cycle unless stalled.
// After the check byte is accepted, the record goes through the record queue,
// then the multiply stage, then the output register; back-pressure can hold it at each.
// The front end stalls only on the byte in the check position while the record queue is full.
// Synchronous active-high reset empties the queue and pipeline and drops any partial frame.
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_temp_frame_decoder_macros.svh"
module humidity_temp_frame_decoder import hfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  hfd_in_if.sink    frame,
  hfd_out_if.source reading
);

  // The front end accepts each request byte, folds the status and payload bytes
  // into the CRC and keeps them. On the check byte it classifies the frame (busy
  // first, then checksum) and hands a complete record to the queue.
  logic       q_push;
  logic       q_space;
  logic       q_pop;
  logic       q_valid;
  frame_rec_t front_rec;
  frame_rec_t back_rec;

  hfd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .space (q_space),
    .push  (q_push),
    .rec   (front_rec)
  );

  // The queue decouples the byte side from the result side, so a stalled consumer
  // does not hold up bytes of the following frame until the queue is full.
  hfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (front_rec),
    .space    (q_space),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_rec  (back_rec)
  );

  // The back end multiplies the raw readings by their scales in one stage and
  // takes the upper bits and the temperature offset into the output register.
  hfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .rec     (back_rec),
    .pop     (q_pop),
    .reading (reading)
  );

  // A set busy bit in the status byte must always be reported as busy, and a
  // clear one never.
  `HFD_ASSERT_IMPLY(a_busy_reported, clk, rst,
    reading.valid && reading.status_byte[7], reading.result_status == ST_BUSY)
  `HFD_ASSERT_IMPLY(a_busy_only_when_set, clk, rst,
    reading.valid && !reading.status_byte[7], reading.result_status != ST_BUSY)

endmodule
`default_nettype wire

@@ design/hfd_front.sv @@
// Front end: tracks frame position, runs the CRC and assembles one record per frame.
// Depends on hfd_pkg, hfd_in_if and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_temp_frame_decoder_macros.svh"
module hfd_front import hfd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  hfd_in_if.sink       frame,
  input  wire logic    space,
  output logic         push,
  output frame_rec_t   rec
);

  logic [2:0] pos;
  logic [7:0] crc;
  logic [7:0] held_status;
  logic [7:0] payload [PAYLOAD_LEN];
  logic       accept;
  logic [2:0] slot;
  logic [7:0] crc_next;
  logic [7:0] low_bits;

  // Only the check byte needs room in the queue.
  assign frame.ready = space || (pos != FRAME_LAST);
  assign accept      = frame.valid && frame.ready;
  assign slot        = 3'(pos - 3'd1);
  assign crc_next    = crc8_byte(frame.frame_start ? CRC_INIT : crc, frame.data_byte);
  assign low_bits    = payload[2] & LOW_NIBBLE;

  assign push = accept && !frame.frame_start && (pos == FRAME_LAST);

  always_comb begin
    rec.status_byte     = held_status;
    rec.computed_check  = crc;
    rec.humidity_raw    = {payload[0], payload[1], payload[2][7:4]};
    rec.temperature_raw = {low_bits[3:0], payload[3], payload[4]};
    if ((held_status & BUSY_MASK) != 8'h00) begin
      rec.result_status = ST_BUSY;
    end else if (crc != frame.data_byte) begin
      rec.result_status = ST_MISMATCH;
    end else begin
      rec.result_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 3'd0;
      crc         <= CRC_INIT;
      held_status <= 8'h00;
    end else if (accept) begin
      if (frame.frame_start) begin
        held_status <= frame.data_byte;
        crc         <= crc_next;
        pos         <= 3'd1;
      end else if (pos == FRAME_LAST) begin
        pos <= 3'd0;
      end else if (pos != 3'd0) begin
        crc <= crc_next;
        pos <= 3'(pos + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !frame.frame_start && pos != 3'd0 && pos != FRAME_LAST) begin
      payload[slot] <= frame.data_byte;
    end
  end

  `HFD_ASSERT_ALWAYS(a_pos_range, clk, rst, pos <= FRAME_LAST)
  `HFD_ASSERT_NEXT(a_idle_byte_ignored, clk, rst,
    accept && !frame.frame_start && pos == 3'd0, pos == 3'd0 && $stable(crc))

endmodule
`default_nettype wire

@@ design/hfd_queue.sv @@
// Small FIFO of frame records between the front end and the conversion pipeline.
// Depends on hfd_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_temp_frame_decoder_macros.svh"
module hfd_queue import hfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire frame_rec_t  push_rec,
  output logic             space,
  input  wire logic        pop,
  output logic             valid,
  output frame_rec_t       pop_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_rec_t    entries [DEPTH];
  logic [PW-1:0] wr;
  logic [PW-1:0] rd;
  logic [CW-1:0] count;

  assign space   = count != CW'(DEPTH);
  assign valid   = count != '0;
  assign pop_rec = entries[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= (wr == PW'(DEPTH - 1)) ? '0 : PW'(wr + 1'b1);
      end
      if (pop) begin
        rd <= (rd == PW'(DEPTH - 1)) ? '0 : PW'(rd + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr] <= push_rec;
    end
  end

  `HFD_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `HFD_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == CW'($past(count) + 1'b1))

endmodule
`default_nettype wire

@@ design/hfd_back.sv @@
// Back end: two-stage pipeline that scales the raw readings to fixed point.
// Depends on hfd_pkg and hfd_out_if.
`timescale 1ns / 1ps
`default_nettype none
module hfd_back import hfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire frame_rec_t  rec,
  output logic             pop,
  hfd_out_if.source        reading
);

  logic               s1_valid;
  frame_rec_t         s1_rec;
  logic [HPROD_W-1:0] hprod;
  logic [TPROD_W-1:0] tprod;
  logic               s1_ready;
  logic               s2_ready;
  logic [14:0]        tfloor;

  assign s2_ready = !reading.valid || reading.ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign pop      = q_valid && s1_ready;
  assign tfloor   = tprod[TPROD_W-1:RAW_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_rec <= rec;
      hprod  <= HPROD_W'(rec.humidity_raw) * HPROD_W'(HUM_SCALE);
      tprod  <= TPROD_W'(rec.temperature_raw) * TPROD_W'(TEMP_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading.valid <= 1'b0;
    end else if (s2_ready) begin
      reading.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      reading.result_status     <= s1_rec.result_status;
      reading.status_byte       <= s1_rec.status_byte;
      reading.humidity_raw      <= s1_rec.humidity_raw;
      reading.temperature_raw   <= s1_rec.temperature_raw;
      reading.computed_check    <= s1_rec.computed_check;
      reading.humidity_centi    <= hprod[HPROD_W-1:RAW_W];
      reading.temperature_centi <= signed'(15'(tfloor - TEMP_OFFSET));
    end
  end

endmodule
`default_nettype wire

@@ dv/humidity_temp_frame_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the humidity/temperature frame decoder.
// Depends on hfd_pkg, the hfd_in_if and hfd_out_if channels and the decoder itself.

module humidity_temp_frame_decoder_tb;
  import hfd_pkg::*;

  // The watchdog fires after this many cycles in which no request moves on either side.
  localparam int STALL_LIMIT   = 4000;
  // Quiet cycles after the last reading, to catch a stray extra one.
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED   = 50;

  // One decoded reading, laid out the way the output channel carries it.
  typedef struct packed {
    logic [1:0]         result_status;
    logic [7:0]         status_byte;
    logic [19:0]        humidity_raw;
    logic [19:0]        temperature_raw;
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;
    logic [7:0]         computed_check;
  } reading_t;

  // Tracks the frame being assembled and the readings the decoder still owes.
  class frame_scoreboard;
    reading_t   readings_due[$];
    int         errors;
    int         bytes_used;
    logic [2:0] position;
    logic [7:0] crc_run;
    logic [7:0] held_status;
    logic [7:0] body [5];

    function new();
      errors      = 0;
      bytes_used  = 0;
      position    = 3'd0;
      crc_run     = CRC_INIT;
      held_status = 8'h00;
      foreach (body[i]) body[i] = 8'h00;
    endfunction

    // Bit-serial form of the CRC-8 update, data taken MSB first.
    static function logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      int         i;
      c = crc;
      for (i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    // Called for every accepted byte request.
    function void note_request(input logic [7:0] b, input logic start);
      reading_t           r;
      logic [19:0]        hraw;
      logic [19:0]        traw;
      longint unsigned    hprod;
      longint unsigned    tprod;
      if (start) begin
        held_status = b;
        crc_run     = crc_fold(CRC_INIT, b);
        position    = 3'd1;
        bytes_used++;
        return;
      end
      if (position == 3'd0) begin
        return;
      end
      bytes_used++;
      if (position < FRAME_LAST) begin
        body[position - 3'd1] = b;
        crc_run  = crc_fold(crc_run, b);
        position = position + 3'd1;
        return;
      end
      // This is the check byte: close the frame and predict the reading.
      position = 3'd0;
      hraw  = {body[0], body[1], body[2][7:4]};
      traw  = {body[2][3:0], body[3], body[4]};
      hprod = 64'(hraw) * 64'd10000;
      tprod = 64'(traw) * 64'd20000;
      if ((held_status & BUSY_MASK) != 8'h00) begin
        r.result_status = ST_BUSY;
      end else if (crc_run != b) begin
        r.result_status = ST_MISMATCH;
      end else begin
        r.result_status = ST_OK;
      end
      r.status_byte       = held_status;
      r.humidity_raw      = hraw;
      r.temperature_raw   = traw;
      r.humidity_centi    = 14'(hprod >> 20);
      r.temperature_centi = 15'(longint'(tprod >> 20) - 64'sd5000);
      r.computed_check    = crc_run;
      readings_due.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
    endtask

    // Called for every accepted reading request.
    task check_reading(input reading_t got);
      reading_t want;
      if (readings_due.size() == 0) begin
        report($sformatf("reading with none due, status_byte %h", got.status_byte));
        return;
      end
      want = readings_due.pop_front();
      if (got.result_status !== want.result_status)
        report($sformatf("result_status %0d, want %0d", got.result_status,
                         want.result_status));
      if (got.status_byte !== want.status_byte)
        report($sformatf("status_byte %h, want %h", got.status_byte, want.status_byte));
      if (got.humidity_raw !== want.humidity_raw)
        report($sformatf("humidity_raw %h, want %h", got.humidity_raw, want.humidity_raw));
      if (got.temperature_raw !== want.temperature_raw)
        report($sformatf("temperature_raw %h, want %h", got.temperature_raw,
                         want.temperature_raw));
      if (got.humidity_centi !== want.humidity_centi)
        report($sformatf("humidity_centi %0d, want %0d", got.humidity_centi,
                         want.humidity_centi));
      if (got.temperature_centi !== want.temperature_centi)
        report($sformatf("temperature_centi %0d, want %0d", got.temperature_centi,
                         want.temperature_centi));
      if (got.computed_check !== want.computed_check)
        report($sformatf("computed_check %h, want %h", got.computed_check,
                         want.computed_check));
    endtask

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   tx_idle_pct = 19;
  int   rx_idle_pct = 79;
  int   stall_cycles;
  logic moved;

  reading_t        seen;
  frame_scoreboard sb;

  hfd_in_if  frame_bus ();
  hfd_out_if reading_bus ();

  humidity_temp_frame_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_bus),
    .reading (reading_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The reading side decides at every falling edge whether it takes a request
  // at the next rising edge. With the idle share at zero it never stalls.
  initial begin
    reading_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      reading_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor and watchdog. Both channels are sampled at the rising edge, before
  // the decoder's own registers update. A reading is checked before the byte of
  // the same edge is noted, so an extra reading can never consume a prediction
  // made at that very edge.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (reading_bus.valid && reading_bus.ready) begin
        seen.result_status     = reading_bus.result_status;
        seen.status_byte       = reading_bus.status_byte;
        seen.humidity_raw      = reading_bus.humidity_raw;
        seen.temperature_raw   = reading_bus.temperature_raw;
        seen.humidity_centi    = reading_bus.humidity_centi;
        seen.temperature_centi = reading_bus.temperature_centi;
        seen.computed_check    = reading_bus.computed_check;
        sb.check_reading(seen);
        moved = 1'b1;
      end
      if (frame_bus.valid && frame_bus.ready) begin
        sb.note_request(frame_bus.data_byte, frame_bus.frame_start);
        moved = 1'b1;
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one byte and returns at the rising edge where it is taken. Valid is
  // left high on return, so back-to-back bytes never see it dropped and raised
  // in the same time step; it only falls when the sender decides to idle.
  task automatic send_byte(input logic [7:0] b, input logic start);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      frame_bus.valid <= 1'b0;
      @(negedge clk);
    end
    frame_bus.valid       <= 1'b1;
    frame_bus.data_byte   <= b;
    frame_bus.frame_start <= start;
    do @(posedge clk); while (frame_bus.ready !== 1'b1);
  endtask

  // Sender goes quiet until every predicted reading has come out.
  task automatic hold_until_drained();
    @(negedge clk);
    frame_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Status byte, then n_payload body bytes taken from the top of payload. Only a
  // full body is followed by a check byte; a shorter one is left open so the
  // next status byte restarts the frame. A corrupt check differs from the CRC.
  task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
                            input int n_payload, input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    int         i;
    crc = frame_scoreboard::crc_fold(CRC_INIT, status);
    send_byte(status, 1'b1);
    for (i = 0; i < n_payload; i++) begin
      b   = payload[39 - 8*i -: 8];
      crc = frame_scoreboard::crc_fold(crc, b);
      send_byte(b, 1'b0);
    end
    if (n_payload == PAYLOAD_LEN) begin
      send_byte(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc, 1'b0);
    end
  endtask

  // Mostly whole frames with random content; some with a bad check, some cut
  // short and restarted, and a few lone bytes sent without a frame start.
  task automatic random_traffic(input int target);
    int          pick;
    logic [7:0]  status;
    logic [39:0] payload;
    while (sb.bytes_used < target) begin
      pick   = $urandom_range(0, 99);
      status = 8'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        status[7] = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: begin
          payload = '0;
        end
        1: begin
          payload = '1;
        end
        default: begin
          payload = {8'($urandom), 32'($urandom)};
        end
      endcase
      if (pick < 5) begin
        send_byte(8'($urandom), 1'b0);
      end else if (pick < 15) begin
        send_frame(status, payload, $urandom_range(0, 4), 1'b0);
      end else begin
        send_frame(status, payload, PAYLOAD_LEN, $urandom_range(0, 4) == 0);
      end
    end
  endtask

  initial begin
    sb                    = new();
    rst                   = 1'b1;
    frame_bus.valid       = 1'b0;
    frame_bus.data_byte   = 8'h00;
    frame_bus.frame_start = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A byte right after reset belongs to no frame and is
    // dropped. An all-zero body gives the lowest readings, here with a bad
    // check. Another stray byte shows the frame closed after its check byte.
    // A frame cut after one body byte is restarted by an all-ones frame with
    // a good check, which gives the highest readings. Last, a busy status with
    // a bad check, where busy must win.
    send_byte(8'hA5, 1'b0);
    send_frame(8'h1C, 40'h00_0000_0000, PAYLOAD_LEN, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_frame(8'h18, 40'hC3_0000_0000, 1, 1'b0);
    send_frame(8'h00, 40'hFF_FFFF_FFFF, PAYLOAD_LEN, 1'b0);
    send_frame(8'hFF, {8'($urandom), 32'($urandom)}, PAYLOAD_LEN, 1'b1);
    hold_until_drained();

    // Random part in three stretches: slow reader, then slow sender, then
    // both at full rate. The sender drains the decoder between stretches.
    random_traffic(600);
    hold_until_drained();
    tx_idle_pct = 79;
    rx_idle_pct = 19;
    random_traffic(1150);
    hold_until_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_traffic(1725);
    hold_until_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ humidity_temp_frame_decoder.f @@
+incdir+design
design/hfd_pkg.sv
design/hfd_in_if.sv
design/hfd_out_if.sv
design/hfd_front.sv
design/hfd_queue.sv
design/hfd_back.sv
design/humidity_temp_frame_decoder.sv
dv/humidity_temp_frame_decoder_tb.sv
